@@ hdl/hgim_pkg.sv @@
// Shared types and constants for the hex grid index mapper.
package hgim_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned ID_W    = 25;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PLANE_W = 17;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned QBITS   = 8;
  localparam int unsigned DIV_STAGES = 2 * QBITS;
  localparam int unsigned NSTAGE  = 3 + DIV_STAGES;
  localparam int unsigned CNT_W   = 3;

  localparam logic [FUNC_W-1:0] F_C2N    = 3'd0;
  localparam logic [FUNC_W-1:0] F_N2C    = 3'd1;
  localparam logic [FUNC_W-1:0] F_E2O    = 3'd2;
  localparam logic [FUNC_W-1:0] F_O2E    = 3'd3;
  localparam logic [FUNC_W-1:0] F_CORNER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_Z = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   pz;
    logic [ID_W-1:0]    id;
    logic [PLANE_W-1:0] nplane;
    logic [PLANE_W-1:0] eplane;
    logic [PLANE_W-1:0] dplane;
    logic [ROW_W-1:0]   drow;
    logic [ID_W-1:0]    totn;
    logic [ID_W-1:0]    tote;
    logic [ID_W-1:0]    pzp;
    logic [17:0]        pyr;
    logic [ID_W-1:0]    n;
    logic [ID_W-1:0]    rem;
    logic [ID_W-1:0]    base;
    logic               ok;
    logic [QBITS-1:0]   qz;
    logic [QBITS-1:0]   qy;
  } work_t;

endpackage

@@ hdl/hgim_in_if.sv @@
// Query channel interface.
interface hgim_in_if;
  logic                           valid;
  logic                           ready;
  logic [hgim_pkg::FUNC_W-1:0]    func;
  logic [hgim_pkg::POS_W-1:0]     pos_x;
  logic [hgim_pkg::POS_W-1:0]     pos_y;
  logic [hgim_pkg::POS_W-1:0]     pos_z;
  logic [hgim_pkg::ID_W-1:0]      item_id;

  modport source (output valid, func, pos_x, pos_y, pos_z, item_id, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, item_id, output ready);
endinterface

@@ hdl/hgim_out_if.sv @@
// Result channel interface.
interface hgim_out_if;
  logic                          valid;
  logic                          ready;
  logic [hgim_pkg::ID_W-1:0]     id_out;
  logic [hgim_pkg::COORD_W-1:0]  x_out;
  logic [hgim_pkg::COORD_W-1:0]  y_out;
  logic [hgim_pkg::COORD_W-1:0]  z_out;
  logic                          valid_res;
  logic                          last;

  modport source (output valid, id_out, x_out, y_out, z_out, valid_res, last, input ready);
  modport sink   (input valid, id_out, x_out, y_out, z_out, valid_res, last, output ready);
endinterface

@@ hdl/hex_grid_index_mapper_top.sv @@
// Top level of the hex grid index mapper.
// Maps 1-based node and element IDs to x,y,z positions on a structured hex grid and back.
// in_ch carries one query word per handshake (func, pos_x/y/z, item_id); out_ch carries
// result words (id_out, x_out/y_out/z_out, valid_res, last). cfg_we/cfg_idx/cfg_data set
// the element counts per axis; write them only while no query is in flight.
// Throughput: one query per cycle while the output is not stalled; a corner query holds
// the output for 8 words, one per cycle, and the pipeline waits behind it. Other
// queries give one word each.
// The pipeline is 19 register stages plus an output register: two stages of
// multiplies, one of range checks, then 16 restoring-division stages (8 for the
// plane quotient, 8 for the row quotient) used by the ID-to-position queries.
// Reset clears all valid bits and sets every element count to 1.
// When a result word is waiting and out_ch.ready is low, the whole pipeline holds and
// in_ch.ready drops; no word is lost or repeated.
module hex_grid_index_mapper_top (
  input  logic                              clk,
  input  logic                              rst_n,
  hgim_in_if.sink                           in_ch,
  hgim_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [hgim_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hgim_pkg::CFG_W-1:0]        cfg_data
);

  logic [hgim_pkg::CFG_W-1:0] ex_r, ey_r, ez_r;
  logic [hgim_pkg::ROW_W-1:0] nx, ny, nz;

  hgim_pkg::work_t st_r   [hgim_pkg::NSTAGE];
  hgim_pkg::work_t st_nxt [hgim_pkg::NSTAGE];
  logic [hgim_pkg::NSTAGE-1:0] v_r;
  hgim_pkg::work_t o_r;
  logic o_v_r;
  logic [hgim_pkg::CNT_W-1:0] cnt_r;
  logic en, fire, done, corner;

  assign nx = {1'b0, ex_r} + 9'd1;
  assign ny = {1'b0, ey_r} + 9'd1;
  assign nz = {1'b0, ez_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r <= 8'd1;
      ey_r <= 8'd1;
      ez_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hgim_pkg::REG_ELEMS_X: ex_r <= cfg_data;
        hgim_pkg::REG_ELEMS_Y: ey_r <= cfg_data;
        hgim_pkg::REG_ELEMS_Z: ez_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic hgim_pkg::work_t fill(
    input logic [2:0] f, input logic [8:0] x, input logic [8:0] y, input logic [8:0] z,
    input logic [24:0] id, input logic [8:0] ax, input logic [8:0] ay,
    input logic [7:0] bx, input logic [7:0] by);
    hgim_pkg::work_t r;
    logic [17:0] np, ep;
    r = '0;
    np = 18'(ax) * 18'(ay);
    ep = 18'(bx) * 18'(by);
    r.func = f;
    r.px = x;
    r.py = y;
    r.pz = z;
    r.id = id;
    r.nplane = np[16:0];
    r.eplane = ep[16:0];
    return r;
  endfunction

  function automatic hgim_pkg::work_t mul_stage(
    input hgim_pkg::work_t w, input logic [8:0] anx, input logic [7:0] bx,
    input logic [8:0] anz, input logic [7:0] bz);
    hgim_pkg::work_t r;
    logic [25:0] tn, te, zp;
    logic sel;
    r = w;
    sel = (w.func == hgim_pkg::F_E2O) || (w.func == hgim_pkg::F_O2E);
    tn = 26'(w.nplane) * 26'(anz);
    te = 26'(w.eplane) * 26'(bz);
    r.totn = tn[24:0];
    r.tote = te[24:0];
    r.dplane = sel ? w.eplane : w.nplane;
    r.drow = sel ? {1'b0, bx} : anx;
    zp = 26'(w.pz) * 26'(r.dplane);
    r.pzp = zp[24:0];
    r.pyr = 18'(w.py) * 18'(r.drow);
    r.n = w.id - 25'd1;
    return r;
  endfunction

  function automatic hgim_pkg::work_t chk_stage(
    input hgim_pkg::work_t w, input logic [8:0] anx, input logic [8:0] any,
    input logic [8:0] anz, input logic [7:0] bx, input logic [7:0] by,
    input logic [7:0] bz);
    hgim_pkg::work_t r;
    logic org_ok;
    r = w;
    org_ok = (w.px < 9'(bx)) && (w.py < 9'(by)) && (w.pz < 9'(bz));
    unique case (w.func)
      hgim_pkg::F_C2N:    r.ok = (w.px < anx) && (w.py < any) && (w.pz < anz);
      hgim_pkg::F_N2C:    r.ok = (w.id != '0) && (w.id <= w.totn);
      hgim_pkg::F_E2O:    r.ok = (w.id != '0) && (w.id <= w.tote) && (w.eplane != '0);
      hgim_pkg::F_O2E:    r.ok = org_ok;
      hgim_pkg::F_CORNER: r.ok = org_ok;
      default:            r.ok = 1'b0;
    endcase
    r.base = w.pzp + 25'(w.pyr) + 25'(w.px) + 25'd1;
    r.rem = w.n;
    r.qz = '0;
    r.qy = '0;
    return r;
  endfunction

  function automatic hgim_pkg::work_t div_stage(input hgim_pkg::work_t w, input int j);
    hgim_pkg::work_t r;
    logic [24:0] sh;
    r = w;
    if (j < hgim_pkg::QBITS) begin
      sh = 25'(w.dplane) << (hgim_pkg::QBITS - 1 - j);
      if (w.rem >= sh) begin
        r.rem = w.rem - sh;
        r.qz[hgim_pkg::QBITS - 1 - j] = 1'b1;
      end
    end else begin
      sh = 25'(w.drow) << (hgim_pkg::DIV_STAGES - 1 - j);
      if (w.rem >= sh) begin
        r.rem = w.rem - sh;
        r.qy[hgim_pkg::DIV_STAGES - 1 - j] = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    st_nxt[0] = fill(in_ch.func, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.item_id,
                     nx, ny, ex_r, ey_r);
    st_nxt[1] = mul_stage(st_r[0], nx, ex_r, nz, ez_r);
    st_nxt[2] = chk_stage(st_r[1], nx, ny, nz, ex_r, ey_r, ez_r);
    for (int j = 0; j < hgim_pkg::DIV_STAGES; j++) begin
      st_nxt[3 + j] = div_stage(st_r[2 + j], j);
    end
  end

  assign corner = o_r.ok && (o_r.func == hgim_pkg::F_CORNER);
  assign fire   = o_v_r && out_ch.ready;
  assign done   = fire && (!corner || (cnt_r == hgim_pkg::CNT_LAST));
  assign en     = !o_v_r || done;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      o_v_r <= 1'b0;
      cnt_r <= '0;
    end else if (en) begin
      v_r   <= {v_r[hgim_pkg::NSTAGE-2:0], in_ch.valid};
      o_v_r <= v_r[hgim_pkg::NSTAGE-1];
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < hgim_pkg::NSTAGE; j++) begin
        st_r[j] <= st_nxt[j];
      end
      o_r <= st_r[hgim_pkg::NSTAGE-1];
    end
  end

  always_comb begin
    out_ch.valid     = o_v_r;
    out_ch.id_out    = '0;
    out_ch.x_out     = '0;
    out_ch.y_out     = '0;
    out_ch.z_out     = '0;
    out_ch.valid_res = 1'b0;
    out_ch.last      = 1'b1;
    if (o_r.ok) begin
      out_ch.valid_res = 1'b1;
      unique case (o_r.func)
        hgim_pkg::F_N2C, hgim_pkg::F_E2O: begin
          out_ch.id_out = o_r.id;
          out_ch.x_out  = o_r.rem[7:0];
          out_ch.y_out  = o_r.qy;
          out_ch.z_out  = o_r.qz;
        end
        hgim_pkg::F_CORNER: begin
          out_ch.id_out = o_r.base + 25'(cnt_r[0])
                        + (cnt_r[1] ? 25'(o_r.drow) : 25'd0)
                        + (cnt_r[2] ? 25'(o_r.dplane) : 25'd0);
          out_ch.x_out  = o_r.px[7:0] + 8'(cnt_r[0]);
          out_ch.y_out  = o_r.py[7:0] + 8'(cnt_r[1]);
          out_ch.z_out  = o_r.pz[7:0] + 8'(cnt_r[2]);
          out_ch.last   = (cnt_r == hgim_pkg::CNT_LAST);
        end
        default: begin
          out_ch.id_out = o_r.base;
          out_ch.x_out  = o_r.px[7:0];
          out_ch.y_out  = o_r.py[7:0];
          out_ch.z_out  = o_r.pz[7:0];
        end
      endcase
    end
  end

endmodule

@@ hdl/hgim_chk.sv @@
// Port checker for the hex grid index mapper, bound to the top level.
module hgim_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hgim_pkg::ID_W-1:0]         out_id,
  input logic [hgim_pkg::COORD_W-1:0]      out_x,
  input logic [hgim_pkg::COORD_W-1:0]      out_y,
  input logic [hgim_pkg::COORD_W-1:0]      out_z,
  input logic                              out_vres,
  input logic                              out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vres |-> out_last)
    else $error("invalid result not marked last");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vres |-> out_id == '0 && out_x == '0 && out_y == '0 && out_z == '0)
    else $error("invalid result carries nonzero fields");

  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hex_grid_index_mapper_top hgim_chk u_hgim_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_id    (out_ch.id_out),
  .out_x     (out_ch.x_out),
  .out_y     (out_ch.y_out),
  .out_z     (out_ch.z_out),
  .out_vres  (out_ch.valid_res),
  .out_last  (out_ch.last)
);
